// ===== rtl/core/wafer_row_die_placer_assert.svh =====
// Assertion macros for the wafer row die placer.
`ifndef WAFER_ROW_DIE_PLACER_ASSERT_SVH
`define WAFER_ROW_DIE_PLACER_ASSERT_SVH

// Same-cycle implication.
`define WRDP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("wafer_row_die_placer: same-cycle check failed");

// Next-cycle implication.
`define WRDP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("wafer_row_die_placer: next-cycle check failed");

`endif

// ===== rtl/core/wrdp_pkg.sv =====
// Shared constants, types and functions of the wafer row die placer.
package wrdp_pkg;

   localparam int MAX_DIES_PER_ROW = 64;
   localparam int COORD_BITS       = 16;
   localparam int CNT_W            = $clog2(MAX_DIES_PER_ROW + 1);
   localparam int Y_W              = 34;
   localparam int X_W              = 26;
   localparam int QUEUE_DEPTH      = 2;
   localparam int CSR_ADDR_W       = 5;

   localparam logic [2:0] REG_CENTER_X   = 3'd0;
   localparam logic [2:0] REG_CENTER_Y   = 3'd1;
   localparam logic [2:0] REG_RADIUS     = 3'd2;
   localparam logic [2:0] REG_DIE_WIDTH  = 3'd3;
   localparam logic [2:0] REG_DIE_HEIGHT = 3'd4;
   localparam logic [2:0] REG_ORIGIN_X   = 3'd5;
   localparam logic [2:0] REG_ORIGIN_Y   = 3'd6;

   localparam logic signed [Y_W-1:0] COORD_HI = Y_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [Y_W-1:0] COORD_LO = -COORD_HI - Y_W'(1);

   typedef struct packed {
      logic [14:0]        center_x;
      logic [14:0]        center_y;
      logic [14:0]        radius;
      logic [14:0]        die_width;
      logic [14:0]        die_height;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
   } cfg_type;

   typedef struct packed {
      logic signed [Y_W-1:0] y;
      logic signed [X_W-1:0] x0;
      logic signed [X_W-1:0] limit;
      logic [14:0]           w;
      logic                  beyond;
      logic                  empty;
      logic                  trunc;
   } row_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // Clamp to the signed coordinate range, then keep the 16 output bits.
   function automatic logic [15:0] sat_coord(input logic signed [Y_W-1:0] v);
      logic signed [Y_W-1:0] c;
      c = v;
      if (v > COORD_HI) c = COORD_HI;
      if (v < COORD_LO) c = COORD_LO;
      return c[15:0];
   endfunction

endpackage

// ===== rtl/core/wrdp_if.sv =====
// Handshake channel interfaces for row requests and die results.
interface wrdp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] row_index;
   modport source (output valid, output row_index, input ready);
   modport sink   (input valid, input row_index, output ready);
endinterface

interface wrdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] die_x;
   logic [15:0] die_y;
   logic        die_valid;
   logic        last_of_row;
   logic        beyond_wafer;
   logic        row_truncated;
   modport source (output valid, output die_x, output die_y, output die_valid,
                   output last_of_row, output beyond_wafer, output row_truncated,
                   input ready);
   modport sink   (input valid, input die_x, input die_y, input die_valid,
                   input last_of_row, input beyond_wafer, input row_truncated,
                   output ready);
endinterface

// ===== rtl/core/wrdp_front.sv =====
// Front part: accepts a row, runs the modulo and square root, builds a row descriptor.
module wrdp_front
   import wrdp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   wrdp_req_if.sink      req,
   input  logic          q_full,
   output logic          q_push,
   output row_desc_type  q_data
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MODY  = 4'd1;
   localparam logic [3:0] S_ROWY  = 4'd2;
   localparam logic [3:0] S_LINE  = 4'd3;
   localparam logic [3:0] S_SQR   = 4'd4;
   localparam logic [3:0] S_SQD   = 4'd5;
   localparam logic [3:0] S_ROOT  = 4'd6;
   localparam logic [3:0] S_MODXI = 4'd7;
   localparam logic [3:0] S_MODX  = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_PUSH  = 4'd10;

   logic [3:0]            state_ff, state_in;
   logic [4:0]            step_ff, step_in;
   logic [15:0]           k_ff, k_in;
   logic [14:0]           w_ff, w_in, h_ff, h_in, d_ff, d_in;
   logic [16:0]           mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [14:0]           rem_ff, rem_in;
   logic signed [16:0]    base_ff, base_in;
   logic signed [Y_W-1:0] y_ff, y_in;
   logic signed [15:0]    b_ff, b_in;
   logic [29:0]           rsq_ff, rsq_in, bsq_ff, bsq_in, sqv_ff, sqv_in;
   logic [15:0]           sqrem_ff, sqrem_in;
   logic [14:0]           root_ff, root_in;
   logic signed [16:0]    left_ff, left_in;
   row_desc_type          desc_ff, desc_in;

   logic [14:0]           w_eff, h_eff, mod_fix;
   logic signed [16:0]    top;
   logic signed [17:0]    vy, vx, first;
   logic [15:0]           rem_sh;
   logic                  div_ge;
   logic [30:0]           kh;
   logic signed [Y_W-1:0] cy_w, r_w, h_w, line, bval;
   logic                  upper, beyond;
   logic signed [31:0]    bsq_full;
   logic [17:0]           sq_sh, sq_trial;
   logic                  sq_ge;
   logic signed [X_W-1:0] x0, right, limit, maxw;

   assign w_eff = (cfg.die_width == 15'd0) ? 15'd1 : cfg.die_width;
   assign h_eff = (cfg.die_height == 15'd0) ? 15'd1 : cfg.die_height;
   assign top   = $signed({2'b00, cfg.center_y}) - $signed({2'b00, cfg.radius});
   assign vy    = {{2{cfg.origin_y[15]}}, cfg.origin_y} - {top[16], top};
   assign vx    = {{2{cfg.origin_x[15]}}, cfg.origin_x} - {left_ff[16], left_ff};

   // One restoring remainder bit per cycle.
   assign rem_sh  = {rem_ff, mag_ff[16]};
   assign div_ge  = rem_sh >= {1'b0, d_ff};
   assign mod_fix = (neg_ff && rem_ff != 15'd0) ? d_ff - rem_ff : rem_ff;

   assign first = {base_ff[16], base_ff} + $signed({3'b000, mod_fix});
   assign kh    = k_ff * h_ff;

   assign cy_w  = $signed({{(Y_W-15){1'b0}}, cfg.center_y});
   assign r_w   = $signed({{(Y_W-15){1'b0}}, cfg.radius});
   assign h_w   = $signed({{(Y_W-15){1'b0}}, h_ff});
   assign upper = (y_ff <<< 1) < ((cy_w <<< 1) + h_w);
   assign line  = upper ? y_ff : y_ff + h_w;
   assign bval  = line - cy_w;
   assign beyond = (!upper && line >= cy_w + r_w) || (bval > r_w) || (bval < -r_w);

   assign bsq_full = b_ff * b_ff;

   // One root bit per cycle, two radicand bits in.
   assign sq_sh    = {sqrem_ff, sqv_ff[29:28]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = sq_sh >= sq_trial;

   assign x0    = $signed({{(X_W-17){left_ff[16]}}, left_ff})
                + $signed({{(X_W-15){1'b0}}, mod_fix});
   assign right = $signed({{(X_W-15){1'b0}}, cfg.center_x})
                + $signed({{(X_W-15){1'b0}}, root_ff});
   assign limit = right - $signed({{(X_W-15){1'b0}}, w_ff});
   assign maxw  = $signed(X_W'(MAX_DIES_PER_ROW) * {{(X_W-15){1'b0}}, w_ff});

   assign req.ready = (state_ff == S_IDLE);
   assign q_push    = (state_ff == S_PUSH) && !q_full;
   assign q_data    = desc_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      d_in     = d_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      base_in  = base_ff;
      y_in     = y_ff;
      b_in     = b_ff;
      rsq_in   = rsq_ff;
      bsq_in   = bsq_ff;
      sqv_in   = sqv_ff;
      sqrem_in = sqrem_ff;
      root_in  = root_ff;
      left_in  = left_ff;
      desc_in  = desc_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               k_in    = req.row_index;
               w_in    = w_eff;
               h_in    = h_eff;
               d_in    = h_eff;
               base_in = top;
               neg_in  = vy[17];
               mag_in  = vy[17] ? 17'(-vy) : vy[16:0];
               rem_in  = '0;
               step_in = '0;
               state_in = S_MODY;
            end
         end
         S_MODY, S_MODX: begin
            rem_in  = div_ge ? 15'(rem_sh - {1'b0, d_ff}) : rem_sh[14:0];
            mag_in  = {mag_ff[15:0], 1'b0};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd16) begin
               state_in = (state_ff == S_MODY) ? S_ROWY : S_FIN;
            end
         end
         S_ROWY: begin
            y_in = $signed({{(Y_W-18){first[17]}}, first})
                 + $signed({{(Y_W-31){1'b0}}, kh});
            state_in = S_LINE;
         end
         S_LINE: begin
            desc_in.y = y_ff;
            b_in = bval[15:0];
            if (beyond) begin
               desc_in.beyond = 1'b1;
               desc_in.empty  = 1'b0;
               desc_in.trunc  = 1'b0;
               state_in = S_PUSH;
            end else begin
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            rsq_in = cfg.radius * cfg.radius;
            bsq_in = bsq_full[29:0];
            state_in = S_SQD;
         end
         S_SQD: begin
            sqv_in   = rsq_ff - bsq_ff;
            sqrem_in = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            sqrem_in = sq_ge ? 16'(sq_sh - sq_trial) : sq_sh[15:0];
            root_in  = {root_ff[13:0], sq_ge};
            sqv_in   = {sqv_ff[27:0], 2'b00};
            step_in  = step_ff + 5'd1;
            if (step_ff == 5'd14) state_in = S_MODXI;
         end
         S_MODXI: begin
            left_in  = $signed({2'b00, cfg.center_x}) - $signed({2'b00, root_ff});
            state_in = S_MODX;
            d_in     = w_ff;
            rem_in   = '0;
            step_in  = '0;
         end
         S_FIN: begin
            desc_in.x0     = x0;
            desc_in.limit  = limit;
            desc_in.w      = w_ff;
            desc_in.beyond = 1'b0;
            desc_in.empty  = !(x0 < limit);
            desc_in.trunc  = (x0 + maxw) < limit;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (!q_full) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // The x modulo needs the left edge, which is only registered on entry.
      if (state_ff == S_MODXI) begin
         neg_in = 1'b0;
         mag_in = '0;
      end
      if (state_ff == S_MODX && step_ff == 5'd0) begin
         neg_in = vx[17];
         mag_in = {(vx[17] ? 17'(-vx) : vx[16:0]) << 1};
         rem_in = {14'd0, (vx[17] ? 17'(-vx) : vx[16:0]) >> 16} >= {1'b0, d_ff}
                  ? '0 : 15'({14'd0, vx[17] ? 1'(17'(-vx) >> 16) : vx[16]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff  <= step_in;
      k_ff     <= k_in;
      w_ff     <= w_in;
      h_ff     <= h_in;
      d_ff     <= d_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      base_ff  <= base_in;
      y_ff     <= y_in;
      b_ff     <= b_in;
      rsq_ff   <= rsq_in;
      bsq_ff   <= bsq_in;
      sqv_ff   <= sqv_in;
      sqrem_ff <= sqrem_in;
      root_ff  <= root_in;
      left_ff  <= left_in;
      desc_ff  <= desc_in;
   end

endmodule

// ===== rtl/core/wrdp_queue.sv =====
// Short queue of row descriptors between the front and back parts.
module wrdp_queue
   import wrdp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  row_desc_type   push_data,
   input  logic           pop,
   output row_desc_type   head,
   output queue_stat_type stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   row_desc_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_QW-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign stat.full  = (count_ff == CNT_QW'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = entry_ff[rd_ff];

   always_comb begin
      wr_in    = push ? ptr_next(wr_ff) : wr_ff;
      rd_in    = pop ? ptr_next(rd_ff) : rd_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + CNT_QW'(1);
      if (!push && pop) count_in = count_ff - CNT_QW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) entry_ff[wr_ff] <= push_data;
   end

endmodule

// ===== rtl/core/wrdp_back.sv =====
// Back part: walks a row descriptor and issues one die result per cycle while the receiver is ready.
module wrdp_back
   import wrdp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  row_desc_type   head,
   input  queue_stat_type q_stat,
   output logic           q_pop,
   wrdp_rsp_if.source     rsp
);

   logic                  valid_ff, valid_in;
   logic [15:0]           x_out_ff, x_out_in, y_out_ff, y_out_in;
   logic                  dv_ff, dv_in, last_ff, last_in, bey_ff, bey_in, tr_ff, tr_in;
   logic signed [X_W-1:0] x_ff, x_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic                  out_free;
   logic signed [X_W-1:0] x_cur, x_nxt;
   logic                  is_last;

   assign out_free = !valid_ff || rsp.ready;
   assign x_cur    = (cnt_ff == '0) ? head.x0 : x_ff;
   assign x_nxt    = x_cur + $signed({{(X_W-15){1'b0}}, head.w});
   assign is_last  = (cnt_ff == CNT_W'(MAX_DIES_PER_ROW - 1)) || (x_nxt >= head.limit);

   always_comb begin
      valid_in = valid_ff;
      x_out_in = x_out_ff;
      y_out_in = y_out_ff;
      dv_in    = dv_ff;
      last_in  = last_ff;
      bey_in   = bey_ff;
      tr_in    = tr_ff;
      x_in     = x_ff;
      cnt_in   = cnt_ff;
      q_pop    = 1'b0;
      if (out_free && !q_stat.empty) begin
         valid_in = 1'b1;
         if (head.beyond || head.empty) begin
            x_out_in = '0;
            y_out_in = '0;
            dv_in    = 1'b0;
            last_in  = 1'b1;
            bey_in   = head.beyond;
            tr_in    = 1'b0;
            q_pop    = 1'b1;
         end else begin
            x_out_in = sat_coord($signed({{(Y_W-X_W){x_cur[X_W-1]}}, x_cur}));
            y_out_in = sat_coord(head.y);
            dv_in    = 1'b1;
            last_in  = is_last;
            bey_in   = 1'b0;
            tr_in    = head.trunc;
            x_in     = x_nxt;
            cnt_in   = is_last ? '0 : cnt_ff + CNT_W'(1);
            q_pop    = is_last;
         end
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      x_out_ff <= x_out_in;
      y_out_ff <= y_out_in;
      dv_ff    <= dv_in;
      last_ff  <= last_in;
      bey_ff   <= bey_in;
      tr_ff    <= tr_in;
      x_ff     <= x_in;
   end

   assign rsp.valid         = valid_ff;
   assign rsp.die_x         = x_out_ff;
   assign rsp.die_y         = y_out_ff;
   assign rsp.die_valid     = dv_ff;
   assign rsp.last_of_row   = last_ff;
   assign rsp.beyond_wafer  = bey_ff;
   assign rsp.row_truncated = tr_ff;

endmodule

// ===== rtl/core/wafer_row_die_placer.sv =====
// Front part: a row inside the wafer goes through two 17-step remainder runs and a 15-step
// square root, with setup states between them, before its descriptor is queued.
// Front takes a new row only once the last is queued; back issues one die result per
// cycle unless the receiver stalls, up to 64 per row, overlapping the next row's front work.
// Reset: synchronous, active high; clears control state and loads the register reset values.
`include "wafer_row_die_placer_assert.svh"
module wafer_row_die_placer
   import wrdp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   wrdp_req_if.sink              req_chan,
   wrdp_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type        cfg_ff, cfg_in;
   logic           q_push, q_pop;
   row_desc_type   q_data, q_head;
   queue_stat_type q_stat;
   logic [2:0]     reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx)
            REG_CENTER_X:   cfg_in.center_x   = csr_pwdata[14:0];
            REG_CENTER_Y:   cfg_in.center_y   = csr_pwdata[14:0];
            REG_RADIUS:     cfg_in.radius     = csr_pwdata[14:0];
            REG_DIE_WIDTH:  cfg_in.die_width  = csr_pwdata[14:0];
            REG_DIE_HEIGHT: cfg_in.die_height = csr_pwdata[14:0];
            REG_ORIGIN_X:   cfg_in.origin_x   = csr_pwdata[15:0];
            REG_ORIGIN_Y:   cfg_in.origin_y   = csr_pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CENTER_X:   csr_prdata = {17'd0, cfg_ff.center_x};
         REG_CENTER_Y:   csr_prdata = {17'd0, cfg_ff.center_y};
         REG_RADIUS:     csr_prdata = {17'd0, cfg_ff.radius};
         REG_DIE_WIDTH:  csr_prdata = {17'd0, cfg_ff.die_width};
         REG_DIE_HEIGHT: csr_prdata = {17'd0, cfg_ff.die_height};
         REG_ORIGIN_X:   csr_prdata = {16'd0, cfg_ff.origin_x};
         REG_ORIGIN_Y:   csr_prdata = {16'd0, cfg_ff.origin_y};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x   <= 15'd0;
         cfg_ff.center_y   <= 15'd0;
         cfg_ff.radius     <= 15'd1;
         cfg_ff.die_width  <= 15'd1;
         cfg_ff.die_height <= 15'd1;
         cfg_ff.origin_x   <= 16'sd0;
         cfg_ff.origin_y   <= 16'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wrdp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_chan),
      .q_full (q_stat.full),
      .q_push (q_push),
      .q_data (q_data)
   );

   wrdp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   wrdp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (q_head),
      .q_stat (q_stat),
      .q_pop  (q_pop),
      .rsp    (rsp_chan)
   );

   `WRDP_ASSERT_IMPL(a_no_overflow, clock, reset, q_push, !q_stat.full)
   `WRDP_ASSERT_IMPL(a_pop_nonempty, clock, reset, q_pop, !q_stat.empty)
   `WRDP_ASSERT_IMPL(a_flag_ends_row, clock, reset, rsp_chan.valid && !rsp_chan.die_valid, rsp_chan.last_of_row && !rsp_chan.row_truncated)
   `WRDP_ASSERT_NEXT(a_row_continues, clock, reset, rsp_chan.valid && rsp_chan.ready && rsp_chan.die_valid && !rsp_chan.last_of_row, rsp_chan.valid && rsp_chan.die_valid)

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the wafer row die placer: row requests in, die positions out.
typedef struct {
   logic [15:0] x;
   logic [15:0] y;
   logic        valid;
   logic        last;
   logic        beyond;
   logic        trunc;
} die_rec_type;

class die_scoreboard;
   longint      geom[7];
   die_rec_type expected_dies[$];
   int          errors;

   function new();
      geom = '{0, 0, 1, 1, 1, 0, 0};
      errors = 0;
   endfunction

   function void set_reg(int idx, logic [31:0] value);
      if (idx < 5) geom[idx] = longint'(value[14:0]);
      else if (idx < 7) geom[idx] = longint'($signed(value[15:0]));
   endfunction

   function longint pos_rem(longint v, longint d);
      longint m;
      m = v % d;
      if (m < 0) m += d;
      return m;
   endfunction

   function longint floor_root(longint v);
      longint res, bit_w;
      res = 0;
      bit_w = 64'sd1 <<< 62;
      while (bit_w > v) bit_w = bit_w >>> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v -= res + bit_w;
            res = (res >>> 1) + bit_w;
         end else begin
            res = res >>> 1;
         end
         bit_w = bit_w >>> 2;
      end
      return res;
   endfunction

   function logic [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function void add_die(longint x, longint y, bit valid, bit last, bit beyond, bit trunc);
      die_rec_type d;
      d.x = clamp16(x);
      d.y = clamp16(y);
      d.valid = valid;
      d.last = last;
      d.beyond = beyond;
      d.trunc = trunc;
      expected_dies = {expected_dies, d};
   endfunction

   // Expand one row request into its list of dies.
   function void note_row(logic [15:0] row);
      longint cx, cy, r, w, h, top, first, y, line, b, a, left, right, x0, lim, n;
      bit trunc;
      cx = geom[0]; cy = geom[1]; r = geom[2];
      w = (geom[3] == 0) ? 1 : geom[3];
      h = (geom[4] == 0) ? 1 : geom[4];
      top = cy - r;
      first = top + pos_rem(geom[6] - top, h);
      y = first + longint'(row) * h;
      if (2 * y < 2 * cy + h) begin
         line = y;
      end else begin
         line = y + h;
         if (line >= cy + r) begin
            add_die(0, 0, 0, 1, 1, 0);
            return;
         end
      end
      b = line - cy;
      if (b > r || b < -r) begin
         add_die(0, 0, 0, 1, 1, 0);
         return;
      end
      a = floor_root(r * r - b * b);
      left = cx - a;
      right = cx + a;
      x0 = left + pos_rem(geom[5] - left, w);
      lim = right - w;
      n = (x0 < lim) ? (lim - x0 - 1) / w + 1 : 0;
      if (n == 0) begin
         add_die(0, 0, 0, 1, 0, 0);
         return;
      end
      trunc = 0;
      if (n > 64) begin
         n = 64;
         trunc = 1;
      end
      for (longint i = 0; i < n; i++)
         add_die(x0 + i * w, y, 1, i == n - 1, 0, trunc);
   endfunction

   function void check_die(die_rec_type act);
      die_rec_type e;
      if (expected_dies.size() == 0) begin
         $display("%0t: unexpected die result x=%h y=%h", $time, act.x, act.y);
         errors++;
         return;
      end
      e = expected_dies.pop_front();
      if (e.x !== act.x || e.y !== act.y || e.valid !== act.valid || e.last !== act.last
          || e.beyond !== act.beyond || e.trunc !== act.trunc) begin
         $display("%0t: mismatch expected x=%h y=%h v=%b l=%b b=%b t=%b", $time,
                  e.x, e.y, e.valid, e.last, e.beyond, e.trunc);
         $display("%0t:          actual   x=%h y=%h v=%b l=%b b=%b t=%b", $time,
                  act.x, act.y, act.valid, act.last, act.beyond, act.trunc);
         errors++;
      end
   endfunction
endclass

module testbench;
   import wrdp_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   wrdp_req_if req_bus();
   wrdp_rsp_if rsp_bus();

   die_scoreboard sb = new();
   int src_idle = 6, dst_idle = 75;
   int items_sent = 0;
   bit hold_now = 0;
   int quiet_cycles = 0;
   int first_rows[12] = '{0, 1, 2, 11, 12, 23, 24, 25, 26, 32768, 16'h5555, 16'hAAAA};

   initial begin
      req_bus.valid = 0;
      req_bus.row_index = '0;
      rsp_bus.ready = 0;
   end

   wafer_row_die_placer i_dut (
      .clock(clock), .reset(reset), .req_chan(req_bus), .rsp_chan(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // Receiver: random back-pressure, plus one long hold-off on request.
   always @(negedge clock) begin
      if (hold_now) begin
         rsp_bus.ready = 0;
         repeat (300) @(negedge clock);
         hold_now = 0;
      end
      rsp_bus.ready = !reset && ($urandom_range(0, 99) >= dst_idle);
   end

   always @(posedge clock) begin
      die_rec_type act;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         act.x = rsp_bus.die_x;
         act.y = rsp_bus.die_y;
         act.valid = rsp_bus.die_valid;
         act.last = rsp_bus.last_of_row;
         act.beyond = rsp_bus.beyond_wafer;
         act.trunc = rsp_bus.row_truncated;
         sb.check_die(act);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= 4000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = CSR_ADDR_W'(idx) << 2;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   task automatic drain();
      while (sb.expected_dies.size() > 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic set_geometry(int cx, int cy, int r, int w, int h, int ox, int oy);
      drain();
      // Random upper bits must be ignored by the block.
      csr_write(REG_CENTER_X, {$urandom} & 32'hFFFF_8000 | cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_RADIUS, r);
      csr_write(REG_DIE_WIDTH, w);
      csr_write(REG_DIE_HEIGHT, h);
      csr_write(REG_ORIGIN_X, ox & 32'hFFFF);
      csr_write(REG_ORIGIN_Y, oy & 32'hFFFF);
   endtask

   task automatic send_row(logic [15:0] row);
      if (items_sent == 80) begin
         src_idle = 75;
         dst_idle = 6;
      end else if (items_sent == 160) begin
         src_idle = 0;
         dst_idle = 0;
      end
      if (items_sent == 175) hold_now = 1;
      while ($urandom_range(0, 99) < src_idle) begin
         req_bus.valid = 0;
         @(negedge clock);
      end
      req_bus.valid = 1;
      req_bus.row_index = row;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_row(row);
      items_sent++;
      @(negedge clock);
      req_bus.valid = 0;
   endtask

   task automatic random_rows(int count);
      longint span;
      span = (2 * sb.geom[2]) / ((sb.geom[4] == 0) ? 1 : sb.geom[4]) + 2;
      if (span > 65535) span = 65535;
      repeat (count) begin
         if ($urandom_range(0, 99) < 85) send_row(16'($urandom_range(0, int'(span))));
         else send_row(16'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset = 0;
      @(negedge clock);
      // Reset geometry: tiny wafer.
      send_row(0);
      send_row(1);
      send_row(16'hFFFF);
      set_geometry(1000, 1000, 300, 20, 25, -7, 13);
      foreach (first_rows[i])
         send_row(16'(first_rows[i]));
      random_rows(10);
      // Narrow dies overflow the row limit.
      set_geometry(500, 400, 200, 3, 40, 5, -3);
      send_row(0);
      send_row(5);
      random_rows(16);
      // Zero steps behave as one.
      set_geometry(100, 100, 50, 0, 0, 3, 9);
      send_row(0);
      send_row(50);
      random_rows(18);
      set_geometry(32767, 32767, 32767, 32767, 32767, -32768, 32767);
      random_rows(15);
      // Coordinates beyond the output range saturate.
      set_geometry(32767, 32767, 30000, 1000, 1000, 32767, -32768);
      random_rows(25);
      set_geometry(0, 0, 5000, 200, 150, -32768, -32768);
      random_rows(25);
      repeat (4) begin
         int r;
         r = $urandom_range(1, 3000);
         set_geometry($urandom_range(0, 32767), $urandom_range(0, 32767), r,
                      $urandom_range(1, r / 20 + 1), $urandom_range(1, r / 8 + 1),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
         random_rows(23);
      end
      // Pause until the block has emptied, then finish.
      while (sb.expected_dies.size() > 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (sb.errors == 0 && sb.expected_dies.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
